// File: src/rdefp_pkg.sv
// Shared constants and helpers for the radar Doppler ego filter projection block.
package rdefp_pkg;

    localparam int ATAN_ENTRIES          = 24;
    localparam int ANGLE_BITS_DEFAULT    = 16;
    localparam int CORDIC_STAGES_DEFAULT = 16;

    localparam int CW = 34;   // CORDIC datapath width, Q2.30 plus growth margin
    localparam int ZW = 33;   // phase accumulator width

    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [17:0]   COORD_MAX    = 18'sd131071;
    localparam logic signed [17:0]   COORD_MIN    = -18'sd131072;
    localparam logic [15:0]          SPEED_LIMIT  = 16'd5120;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_MOUNT    = 3'd1;
    localparam logic [2:0] REG_MIRROR   = 3'd2;
    localparam logic [2:0] REG_SENSOR_X = 3'd3;
    localparam logic [2:0] REG_SENSOR_Y = 3'd4;
    localparam logic [2:0] REG_SPEED    = 3'd5;
    localparam logic [2:0] REG_YAW_RATE = 3'd6;

    // Arctangent of 2^-i in 2^32-per-turn units.
    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3:  t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9:  t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return signed'({1'b0, t});
    endfunction

    // Round a Q30 product to nearest, ties toward +infinity.
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] s;
        s = (v + 66'sd536870912) >>> 30;
        return s[35:0];
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
        if (v > 36'sd131071)
            return COORD_MAX;
        else if (v < -36'sd131072)
            return COORD_MIN;
        else
            return v[17:0];
    endfunction

endpackage

// File: src/rdefp_cordic_cell.sv
// One CORDIC rotation cell for three angle channels, with a sideband carried alongside.
module rdefp_cordic_cell
    import rdefp_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x [3],
    input  logic signed [CW-1:0] in_y [3],
    input  logic signed [ZW-1:0] in_z [3],
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x [3],
    output logic signed [CW-1:0] out_y [3],
    output logic signed [ZW-1:0] out_z [3],
    output logic [SIDE_W-1:0]    out_side
);

    localparam logic signed [ZW-1:0] ATAN = atan_turn(STAGE);

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg [3];
    logic signed [CW-1:0] y_reg [3];
    logic signed [ZW-1:0] z_reg [3];
    logic [SIDE_W-1:0]    side_reg;
    logic signed [CW-1:0] x_next [3];
    logic signed [CW-1:0] y_next [3];
    logic signed [ZW-1:0] z_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!in_z[c][ZW-1]) begin
                x_next[c] = in_x[c] - (in_y[c] >>> STAGE);
                y_next[c] = in_y[c] + (in_x[c] >>> STAGE);
                z_next[c] = in_z[c] - ATAN;
            end else begin
                x_next[c] = in_x[c] + (in_y[c] >>> STAGE);
                y_next[c] = in_y[c] - (in_x[c] >>> STAGE);
                z_next[c] = in_z[c] + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// File: src/radar_doppler_ego_filter_projection_core.sv
// Top level: radar detection projection with ego-motion Doppler compensation.
//
// Usage:
//   Input channel s_* carries one detection per transaction (range, azimuth,
//   elevation, radial speed); result channel m_* returns exactly one result
//   per detection, in order: point and tip coordinates, show flag, colour.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while the block is idle. Unknown indexes are ignored.
// Throughput: one transaction per cycle unless the output stalls, set by the CORDIC
//   cells, each rotating three angles (azimuth, elevation, compensation) per cycle.
// Pipeline: from input to result valid a transaction passes one input register,
//   CORDIC_STAGES cells (capped at ATAN_ENTRIES, 24), then six more stages: two
//   multiply levels each followed by rounding (the compensation sum and the
//   filter ride along), the colour scale and the output register.
// Reset: aresetn clears all valid bits and the configuration registers
//   (static mode); datapath registers fill as transactions flow in.
// Stall: the whole pipeline advances only while the output register is free
//   or being emptied; when m_ready is low with a result held, every stage
//   holds and s_ready drops, so no transaction is lost.
module radar_doppler_ego_filter_projection_core
    import rdefp_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEFAULT,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_target_range,
    input  logic signed [15:0] s_azimuth,
    input  logic signed [15:0] s_elevation,
    input  logic signed [15:0] s_radial_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_point_x,
    output logic signed [17:0] m_point_y,
    output logic signed [17:0] m_point_z,
    output logic signed [17:0] m_tip_x,
    output logic signed [17:0] m_tip_y,
    output logic signed [17:0] m_tip_z,
    output logic               m_show_point,
    output logic [7:0]         m_red_level,
    output logic [7:0]         m_green_level
);

    localparam int NST    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    // Sideband: range, radial speed, flip flags for the three angles.
    localparam int SIDE_W = 16 + 16 + 3;

    // ---------------- configuration registers ----------------
    logic               mode_reg, mirror_reg;
    logic signed [15:0] mount_reg, sx_reg, sy_reg, speed_reg, yaw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            mirror_reg <= 1'b0;
            mount_reg  <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            speed_reg  <= '0;
            yaw_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg   <= cfg_data[0];
                REG_MOUNT:    mount_reg  <= cfg_data;
                REG_MIRROR:   mirror_reg <= cfg_data[0];
                REG_SENSOR_X: sx_reg     <= cfg_data;
                REG_SENSOR_Y: sy_reg     <= cfg_data;
                REG_SPEED:    speed_reg  <= cfg_data;
                REG_YAW_RATE: yaw_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sensor velocity depends on configuration only; register it once.
    // The yaw term reaches 2^18, so both components need 20 bits.
    logic signed [31:0] yx_reg, yy_reg;
    logic signed [19:0] vx_reg, vy_reg;
    always_ff @(posedge aclk) begin
        logic signed [31:0] ry, rx;
        ry     = (yy_reg + 32'sd2048) >>> 12;
        rx     = (yx_reg + 32'sd2048) >>> 12;
        yx_reg <= yaw_reg * sx_reg;
        yy_reg <= yaw_reg * sy_reg;
        vx_reg <= 20'(32'(speed_reg) - ry);
        vy_reg <= rx[19:0];
    end

    // ---------------- pipeline control ----------------
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- angle preparation ----------------
    function automatic logic [31:0] to_phase(input logic [15:0] a);
        logic [31:0] p;
        p = {a, 16'h0};
        p = p & ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
        return p;
    endfunction

    logic [15:0] phi_in;
    logic [31:0] ph [3];
    logic [2:0]  flip;
    logic signed [CW-1:0] c_x [NST+1][3];
    logic signed [CW-1:0] c_y [NST+1][3];
    logic signed [ZW-1:0] c_z [NST+1][3];
    logic [SIDE_W-1:0]    c_side [NST+1];
    logic                 c_valid [NST+1];

    assign phi_in = (mirror_reg ? -s_azimuth : s_azimuth) + mount_reg;

    always_comb begin
        logic [31:0] p;
        for (int c = 0; c < 3; c++) begin
            p = to_phase(c == 0 ? s_azimuth : (c == 1 ? s_elevation : phi_in));
            flip[c] = p[31] ^ p[30];
            ph[c]   = flip[c] ? p + 32'h80000000 : p;
        end
    end

    logic                 v0_reg;
    logic signed [ZW-1:0] z0_reg [3];
    logic [SIDE_W-1:0]    side0_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) z0_reg[c] <= signed'({ph[c][31], ph[c]});
            side0_reg <= {s_target_range, s_radial_speed, flip};
        end
    end

    always_comb begin
        c_valid[0] = v0_reg;
        c_side[0]  = side0_reg;
        for (int c = 0; c < 3; c++) begin
            c_x[0][c] = CORDIC_START;
            c_y[0][c] = '0;
            c_z[0][c] = z0_reg[c];
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_cell
        rdefp_cordic_cell #(.STAGE(g), .SIDE_W(SIDE_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (c_valid[g]),
            .in_x     (c_x[g]),
            .in_y     (c_y[g]),
            .in_z     (c_z[g]),
            .in_side  (c_side[g]),
            .out_valid(c_valid[g+1]),
            .out_x    (c_x[g+1]),
            .out_y    (c_y[g+1]),
            .out_z    (c_z[g+1]),
            .out_side (c_side[g+1])
        );
    end

    // ---------------- stage A: flip and first products ----------------
    logic signed [CW-1:0] cs [3], sn [3];
    logic [15:0]          rng_w;
    logic signed [15:0]   rs_w;
    always_comb begin
        {rng_w, rs_w} = c_side[NST][SIDE_W-1:3];
        for (int c = 0; c < 3; c++) begin
            cs[c] = c_side[NST][c] ? -c_x[NST][c] : c_x[NST][c];
            sn[c] = c_side[NST][c] ? -c_y[NST][c] : c_y[NST][c];
        end
    end

    logic                 va_reg;
    logic signed [17:0]   rsa_reg;
    logic signed [CW-1:0] ca_a_reg, sa_a_reg;
    logic signed [51:0]   hp_reg, htp_reg, zp_reg, ztp_reg, cvx_reg, cvy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (en)  va_reg <= c_valid[NST];
    end
    always_ff @(posedge aclk) begin
        logic signed [17:0] r, rt;
        if (en) begin
            r        = signed'({2'b0, rng_w});
            rt       = r + 18'(rs_w);
            rsa_reg  <= 18'(rs_w);
            ca_a_reg <= cs[0];
            sa_a_reg <= sn[0];
            hp_reg   <= 52'(r * cs[1]);
            htp_reg  <= 52'(rt * cs[1]);
            zp_reg   <= 52'(r * sn[1]);
            ztp_reg  <= 52'(rt * sn[1]);
            cvx_reg  <= 52'(vx_reg * cs[2]);
            cvy_reg  <= 52'(vy_reg * sn[2]);
        end
    end

    // ---------------- stage B: round heights, sum compensation ----------------
    logic                 vb_reg;
    logic signed [17:0]   rsb_reg, h_reg, ht_reg, zb_reg, ztb_reg;
    logic signed [CW-1:0] ca_b_reg, sa_b_reg;
    logic signed [53:0]   csum_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en)  vb_reg <= va_reg;
    end
    always_ff @(posedge aclk) begin
        logic signed [35:0] t;
        if (en) begin
            rsb_reg  <= rsa_reg;
            ca_b_reg <= ca_a_reg;
            sa_b_reg <= sa_a_reg;
            t = rnd30(66'(hp_reg));  h_reg   <= t[17:0];
            t = rnd30(66'(htp_reg)); ht_reg  <= t[17:0];
            t = rnd30(66'(zp_reg));  zb_reg  <= sat18(t);
            t = rnd30(66'(ztp_reg)); ztb_reg <= sat18(t);
            csum_reg <= 54'(cvx_reg) + 54'(cvy_reg);
        end
    end

    // ---------------- stage C: second products, rate ----------------
    logic                 vc_reg;
    logic signed [17:0]   rsc_reg, zc_reg, ztc_reg;
    logic signed [51:0]   xp_reg, yp_reg, xtp_reg, ytp_reg;
    logic signed [23:0]   rate_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (en)  vc_reg <= vb_reg;
    end
    always_ff @(posedge aclk) begin
        logic signed [35:0] t;
        if (en) begin
            rsc_reg  <= rsb_reg;
            zc_reg   <= zb_reg;
            ztc_reg  <= ztb_reg;
            xp_reg   <= 52'(h_reg * ca_b_reg);
            yp_reg   <= 52'(h_reg * sa_b_reg);
            xtp_reg  <= 52'(ht_reg * ca_b_reg);
            ytp_reg  <= 52'(ht_reg * sa_b_reg);
            t = rnd30(66'(csum_reg));
            rate_reg <= 24'(t) + 24'(rsb_reg);
        end
    end

    // ---------------- stage D: round coordinates, filter ----------------
    logic               vd_reg;
    logic signed [17:0] xd_reg, yd_reg, zd_reg, xtd_reg, ytd_reg, ztd_reg;
    logic               showd_reg, posd_reg;
    logic [16:0]        pd_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (en)  vd_reg <= vc_reg;
    end
    always_ff @(posedge aclk) begin
        logic [23:0] ar;
        logic [16:0] ars;
        if (en) begin
            xd_reg  <= sat18(rnd30(66'(xp_reg)));
            yd_reg  <= sat18(rnd30(66'(yp_reg)));
            xtd_reg <= sat18(rnd30(66'(xtp_reg)));
            ytd_reg <= sat18(rnd30(66'(ytp_reg)));
            zd_reg  <= zc_reg;
            ztd_reg <= ztc_reg;
            ar  = rate_reg[23] ? 24'(-rate_reg) : 24'(rate_reg);
            ars = rsc_reg[17] ? 17'(-rsc_reg) : 17'(rsc_reg);
            showd_reg <= !mode_reg ||
                         ((ars <= 17'(SPEED_LIMIT)) &&
                          (signed'({4'b0, ar} * 28'sd5) >= 28'sd320 + 28'(speed_reg)));
            posd_reg  <= rsc_reg > 0;
            pd_reg    <= (ars > 17'(SPEED_LIMIT)) ? 17'(SPEED_LIMIT) : ars;
        end
    end

    // ---------------- stage E: colour scale ----------------
    logic               ve_reg;
    logic signed [17:0] xe_reg, ye_reg, ze_reg, xte_reg, yte_reg, zte_reg;
    logic               showe_reg, pose_reg;
    logic [17:0]        qm_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (en)  ve_reg <= vd_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            {xe_reg, ye_reg, ze_reg}    <= {xd_reg, yd_reg, zd_reg};
            {xte_reg, yte_reg, zte_reg} <= {xtd_reg, ytd_reg, ztd_reg};
            showe_reg <= showd_reg;
            pose_reg  <= posd_reg;
            // (p*255 + 2560) / 5120 equals (p*51 + 512) / 1024: the divide is a shift
            qm_reg    <= 18'(pd_reg) * 18'd51 + 18'd512;
        end
    end

    // ---------------- output register ----------------
    logic               vo_reg;
    logic signed [17:0] xo_reg, yo_reg, zo_reg, xto_reg, yto_reg, zto_reg;
    logic               showo_reg;
    logic [7:0]         red_reg, green_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (en)  vo_reg <= ve_reg;
    end
    always_ff @(posedge aclk) begin
        logic [7:0] q;
        if (en) begin
            {xo_reg, yo_reg, zo_reg}    <= {xe_reg, ye_reg, ze_reg};
            {xto_reg, yto_reg, zto_reg} <= {xte_reg, yte_reg, zte_reg};
            showo_reg <= showe_reg;
            q = qm_reg[17:10];
            if (!mode_reg || !showe_reg) begin
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
            end else if (pose_reg) begin
                red_reg   <= 8'd255 - q;
                green_reg <= 8'd255;
            end else begin
                red_reg   <= 8'd255;
                green_reg <= 8'd255 - q;
            end
        end
    end

    assign m_valid       = vo_reg;
    assign m_point_x     = xo_reg;
    assign m_point_y     = yo_reg;
    assign m_point_z     = zo_reg;
    assign m_tip_x       = xto_reg;
    assign m_tip_y       = yto_reg;
    assign m_tip_z       = zto_reg;
    assign m_show_point  = showo_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_point_x) && $stable(m_red_level))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");
    a_static_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !mode_reg) |-> m_show_point && m_red_level == 8'd0)
        else $error("static mode colour");
    a_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_show_point) |-> m_red_level == 8'd0 && m_green_level == 8'd0)
        else $error("hidden point coloured");

endmodule
